// ----- hdl/mutf8_pkg.sv -----
// Shared types and byte codes for the modified UTF-8 to UTF-8 transcoder.
// No dependencies; every other file in hdl/ imports this package.
package mutf8_pkg;

  localparam int WIN_DEPTH    = 5;  // held bytes in the match window
  localparam int GRP_MAX      = 6;  // most bytes one input item can release
  localparam int GQ_DEPTH_DEF = 4;  // default depth of the group queue

  localparam logic [7:0] BYTE_NUL   = 8'h00;
  localparam logic [7:0] BYTE_C0    = 8'hC0;
  localparam logic [7:0] BYTE_80    = 8'h80;
  localparam logic [7:0] BYTE_ED    = 8'hED;
  localparam logic [7:0] HI_SURR_LO = 8'hA0;
  localparam logic [7:0] HI_SURR_HI = 8'hAF;
  localparam logic [7:0] LO_SURR_LO = 8'hB0;
  localparam logic [7:0] LO_SURR_HI = 8'hBF;

  // Output bytes released by one input item; len is 1..GRP_MAX when queued.
  typedef struct packed {
    logic [GRP_MAX-1:0][7:0] bytes;
    logic [2:0]              len;
    logic                    term;   // last byte closes the string
  } group_t;

endpackage

// ----- hdl/mutf8_front.sv -----
// Front end: accepts input bytes, tracks the match window, and builds the
// group of output bytes each item releases. Depends on mutf8_pkg.
module mutf8_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [7:0]        in_byte,
  input  logic              full,
  output logic              gq_wr,
  output mutf8_pkg::group_t gq_data
);
  import mutf8_pkg::*;

  logic [WIN_DEPTH-1:0][7:0] win_r, win_nxt;
  logic [2:0]                cnt_r, cnt_nxt;
  logic                      accept;
  group_t                    grp;
  logic [2:0]                n;
  logic                      tail_en;
  logic                      b_hi, b_lo;
  logic [10:0]               plane;
  logic [20:0]               code;

  assign accept = push && !full;
  assign b_hi   = (in_byte >= HI_SURR_LO) && (in_byte <= HI_SURR_HI);
  assign b_lo   = (in_byte >= LO_SURR_LO) && (in_byte <= LO_SURR_HI);

  // Code point of a completed surrogate pair; only the low payload bits count.
  assign plane = {1'b0, win_r[1][3:0], win_r[2][5:0]} + 11'h040;
  assign code  = {plane, win_r[4][3:0], in_byte[5:0]};

  always_comb begin
    grp     = '0;
    n       = '0;
    win_nxt = win_r;
    cnt_nxt = cnt_r;
    tail_en = 1'b0;
    if (in_byte == BYTE_NUL) begin
      // Flush everything held, then the terminator.
      grp.bytes[WIN_DEPTH-1:0] = win_r;
      grp.bytes[cnt_r]         = BYTE_NUL;
      n                        = cnt_r + 3'd1;
      grp.term                 = 1'b1;
      cnt_nxt                  = '0;
    end else if (cnt_r == 3'd0) begin
      tail_en = 1'b1;
    end else if (cnt_r == 3'd1 && win_r[0] == BYTE_C0) begin
      if (in_byte == BYTE_80) begin
        cnt_nxt = '0;  // drop the encoded NUL
      end else begin
        grp.bytes[n] = BYTE_C0; n = n + 3'd1;
        tail_en = 1'b1;
      end
    end else begin
      // Window holds a surrogate-pair prefix of cnt_r bytes.
      unique case (cnt_r)
        3'd1: begin
          if (b_hi) begin
            win_nxt[1] = in_byte; cnt_nxt = 3'd2;
          end else begin
            grp.bytes[n] = BYTE_ED; n = n + 3'd1;
            tail_en = 1'b1;
          end
        end
        3'd2: begin
          win_nxt[2] = in_byte; cnt_nxt = 3'd3;
        end
        3'd3: begin
          if (in_byte == BYTE_ED) begin
            win_nxt[3] = in_byte; cnt_nxt = 3'd4;
          end else begin
            grp.bytes[n] = BYTE_ED;  n = n + 3'd1;
            grp.bytes[n] = win_r[1]; n = n + 3'd1;
            cnt_nxt = '0;
            if (win_r[2] == BYTE_C0) begin
              if (in_byte != BYTE_80) begin
                grp.bytes[n] = BYTE_C0; n = n + 3'd1;
                tail_en = 1'b1;
              end
            end else if (win_r[2] == BYTE_ED) begin
              if (b_hi) begin
                win_nxt[0] = BYTE_ED; win_nxt[1] = in_byte; cnt_nxt = 3'd2;
              end else begin
                grp.bytes[n] = BYTE_ED; n = n + 3'd1;
                tail_en = 1'b1;
              end
            end else begin
              grp.bytes[n] = win_r[2]; n = n + 3'd1;
              tail_en = 1'b1;
            end
          end
        end
        3'd4: begin
          if (b_lo) begin
            win_nxt[4] = in_byte; cnt_nxt = 3'd5;
          end else begin
            // Rescan lets the second ED start a new prefix when a high surrogate byte follows.
            grp.bytes[n] = BYTE_ED;  n = n + 3'd1;
            grp.bytes[n] = win_r[1]; n = n + 3'd1;
            grp.bytes[n] = win_r[2]; n = n + 3'd1;
            if (b_hi) begin
              win_nxt[0] = BYTE_ED; win_nxt[1] = in_byte; cnt_nxt = 3'd2;
            end else begin
              grp.bytes[n] = BYTE_ED; n = n + 3'd1;
              cnt_nxt = '0;
              tail_en = 1'b1;
            end
          end
        end
        3'd5: begin
          grp.bytes[0] = {5'b11110, code[20:18]};
          grp.bytes[1] = {2'b10, code[17:12]};
          grp.bytes[2] = {2'b10, code[11:6]};
          grp.bytes[3] = {2'b10, code[5:0]};
          n       = 3'd4;
          cnt_nxt = '0;
        end
        default: cnt_nxt = '0;
      endcase
    end
    if (tail_en) begin
      if (in_byte == BYTE_C0 || in_byte == BYTE_ED) begin
        win_nxt[0] = in_byte; cnt_nxt = 3'd1;
      end else begin
        grp.bytes[n] = in_byte; n = n + 3'd1;
        cnt_nxt = '0;
      end
    end
    grp.len = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (accept) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
  end

  assign gq_wr   = accept && (grp.len != 3'd0);
  assign gq_data = grp;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(WIN_DEPTH))
    else $error("window count beyond depth");

  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_byte == BYTE_NUL) |=> (cnt_r == 3'd0))
    else $error("window not emptied by terminator");

  a_grp_len: assert property (@(posedge clk) disable iff (!rst_n)
    gq_wr |-> (gq_data.len <= 3'(GRP_MAX)))
    else $error("group longer than allowed");

endmodule

// ----- hdl/mutf8_queue.sv -----
// Short group queue between front and back end.
// Depends on mutf8_pkg for group_t.
module mutf8_queue #(
  parameter int DEPTH = mutf8_pkg::GQ_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  mutf8_pkg::group_t wr_data,
  output logic              full,
  input  logic              rd_en,
  output mutf8_pkg::group_t rd_data,
  output logic              empty
);
  import mutf8_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  group_t          mem_r [DEPTH];
  logic [AW-1:0]   wp_r, rp_r;
  logic [CW-1:0]   count_r;
  logic            do_wr, do_rd;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
      end
      if (do_rd) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + CW'(1);
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  assign rd_data = mem_r[rp_r];

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && full))
    else $error("group written while queue full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && empty))
    else $error("group read while queue empty");

endmodule

// ----- hdl/mutf8_back.sv -----
// Back end: walks each queued group one byte per cycle into the output
// register while the result side pops. Depends on mutf8_pkg for group_t.
module mutf8_back (
  input  logic              clk,
  input  logic              rst_n,
  input  mutf8_pkg::group_t gq_data,
  input  logic              gq_empty,
  output logic              gq_rd,
  input  logic              pop,
  output logic              empty,
  output logic [7:0]        out_byte,
  output logic              out_end_of_string
);
  import mutf8_pkg::*;

  logic       ov_r, ov_nxt;
  logic [7:0] ob_r;
  logic       oe_r;
  logic [2:0] idx_r, idx_nxt;
  logic       load, last;

  assign last  = (idx_r == gq_data.len - 3'd1);
  assign load  = !gq_empty && (!ov_r || pop);
  assign gq_rd = load && last;

  always_comb begin
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = last ? 3'd0 : idx_r + 3'd1;
    end
    ov_nxt = ov_r;
    if (load) begin
      ov_nxt = 1'b1;
    end else if (pop) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      idx_r <= '0;
    end else begin
      ov_r  <= ov_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ob_r <= gq_data.bytes[idx_r];
      oe_r <= gq_data.term && last;
    end
  end

  assign empty             = !ov_r;
  assign out_byte          = ob_r;
  assign out_end_of_string = oe_r;

  a_eos_is_nul: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && oe_r) |-> (ob_r == BYTE_NUL))
    else $error("end of string on a nonzero byte");

  a_idx_in_group: assert property (@(posedge clk) disable iff (!rst_n)
    !gq_empty |-> (idx_r < gq_data.len))
    else $error("byte index past group length");

endmodule

// ----- hdl/modified_utf8_to_utf8.sv -----
// Top level of the modified UTF-8 to UTF-8 transcoder.
// Depends on mutf8_pkg, mutf8_front, mutf8_queue and mutf8_back.
//
//   channel  handshake     payload                     direction
//   input    push / full   in_byte[7:0]                in
//   result   pop / empty   out_byte[7:0], out_end_of_string  out
//
// One input byte is taken per cycle while the group queue has room; the
// front end settles each byte in the same cycle it is accepted.
// Results leave one byte per cycle from the output register while the result
// side pops; each group passes from the queue into that register, and a group holds up to six bytes.
// Reset empties the window, the group queue and the output register.
// A stalled result side fills the queue, then full rises; input stalls
// do not disturb bytes already queued.
module modified_utf8_to_utf8 #(
  parameter int GQ_DEPTH = mutf8_pkg::GQ_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic       out_end_of_string
);
  import mutf8_pkg::*;

  group_t wr_grp, rd_grp;
  logic   gq_wr, gq_rd, gq_full, gq_empty;

  assign full = gq_full;

  mutf8_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_byte (in_byte),
    .full    (gq_full),
    .gq_wr   (gq_wr),
    .gq_data (wr_grp)
  );

  mutf8_queue #(
    .DEPTH (GQ_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (gq_wr),
    .wr_data (wr_grp),
    .full    (gq_full),
    .rd_en   (gq_rd),
    .rd_data (rd_grp),
    .empty   (gq_empty)
  );

  mutf8_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .gq_data           (rd_grp),
    .gq_empty          (gq_empty),
    .gq_rd             (gq_rd),
    .pop               (pop),
    .empty             (empty),
    .out_byte          (out_byte),
    .out_end_of_string (out_end_of_string)
  );

endmodule

// ----- tb/tb_modified_utf8_to_utf8.sv -----
`timescale 1ns / 1ps
// Testbench for modified_utf8_to_utf8: directed strings, then random byte streams.
// Depends on mutf8_pkg and the RTL in hdl/; a scoreboard class predicts every result.

class mutf8_scoreboard;
  typedef struct {
    logic [7:0] data;
    logic       eos;
  } result_t;

  result_t    want_q[$];
  logic [7:0] win[6];
  int         held;
  int         errors;

  function new();
    held   = 0;
    errors = 0;
    foreach (win[i]) win[i] = 8'h00;
  endfunction

  function int pending();
    return want_q.size();
  endfunction

  function void push_result(logic [7:0] d, logic e);
    result_t r;
    r.data = d;
    r.eos  = e;
    want_q.push_back(r);
  endfunction

  function void release_front(int cnt);
    if (cnt >= held) begin
      held = 0;
      return;
    end
    for (int j = 0; j + cnt < held; j++) win[j] = win[j + cnt];
    held -= cnt;
  endfunction

  // Position pos of a surrogate pair, counted from the leading ED.
  function bit pair_ok(int pos, logic [7:0] v);
    case (pos)
      1:       return v >= mutf8_pkg::HI_SURR_LO && v <= mutf8_pkg::HI_SURR_HI;
      3:       return v == mutf8_pkg::BYTE_ED;
      4:       return v >= mutf8_pkg::LO_SURR_LO && v <= mutf8_pkg::LO_SURR_HI;
      default: return v != mutf8_pkg::BYTE_NUL;
    endcase
  endfunction

  // Release whatever the held bytes settle to; at_end means no byte can follow.
  function void settle(bit at_end);
    logic [7:0]  b0;
    bit          ok;
    int unsigned hi_s, lo_s, cp;
    while (held > 0) begin
      b0 = win[0];
      if (b0 == mutf8_pkg::BYTE_C0) begin
        if (held < 2) begin
          if (!at_end) return;
        end else if (win[1] == mutf8_pkg::BYTE_80) begin
          release_front(2);
          continue;
        end
      end else if (b0 == mutf8_pkg::BYTE_ED) begin
        ok = 1'b1;
        for (int i = 1; i < held && i < 6; i++)
          if (!pair_ok(i, win[i])) ok = 1'b0;
        if (ok && held >= 6) begin
          hi_s = 32'hD000 | (32'(win[1][5:0]) << 6) | 32'(win[2][5:0]);
          lo_s = 32'hD000 | (32'(win[4][5:0]) << 6) | 32'(win[5][5:0]);
          cp   = 32'h10000 + ((hi_s - 32'hD800) << 10) + (lo_s - 32'hDC00);
          push_result(8'hF0 | 8'(cp >> 18), 1'b0);
          push_result(8'h80 | {2'b00, cp[17:12]}, 1'b0);
          push_result(8'h80 | {2'b00, cp[11:6]}, 1'b0);
          push_result(8'h80 | {2'b00, cp[5:0]}, 1'b0);
          release_front(6);
          continue;
        end
        if (ok && !at_end) return;
      end
      push_result(b0, 1'b0);
      release_front(1);
    end
  endfunction

  function void note_input(logic [7:0] v);
    if (v == mutf8_pkg::BYTE_NUL) begin
      settle(1'b1);
      push_result(mutf8_pkg::BYTE_NUL, 1'b1);
      held = 0;
      foreach (win[i]) win[i] = 8'h00;
    end else begin
      win[held] = v;
      held++;
      settle(1'b0);
      if (held > 5) held = 5;
    end
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 40) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task check_result(logic [7:0] d, logic e);
    result_t w;
    if (want_q.size() == 0) begin
      report($sformatf("unexpected item out_byte=%02h eos=%0b", d, e));
      return;
    end
    w = want_q.pop_front();
    if (d !== w.data) report($sformatf("out_byte %02h, want %02h", d, w.data));
    if (e !== w.eos) report($sformatf("out_end_of_string %0b, want %0b", e, w.eos));
  endtask
endclass

module tb_modified_utf8_to_utf8;
  import mutf8_pkg::*;

  localparam int IDLE_LIMIT = 500;

  logic       clk;
  logic       rst_n;
  logic       push;
  logic       full;
  logic [7:0] in_byte;
  logic       pop;
  logic       empty;
  logic [7:0] out_byte;
  logic       out_end_of_string;

  mutf8_scoreboard sb = new();
  bit              quiet_in;
  int              idle_cycles;

  modified_utf8_to_utf8 u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_byte          (in_byte),
    .pop              (pop),
    .empty            (empty),
    .out_byte         (out_byte),
    .out_end_of_string(out_end_of_string)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hold push high through back-to-back items; lower it only for a gap.
  task send_item(logic [7:0] v);
    int gap;
    gap = quiet_in ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push    <= 1'b1;
    in_byte <= v;
    do @(posedge clk); while (full);
    sb.note_input(v);
  endtask

  initial begin
    logic [7:0] stim_q[$];
    logic [7:0] p[6];
    int         len;
    int         sel;
    rst_n   = 1'b0;
    push    = 1'b0;
    in_byte = 8'h00;
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // bare terminator, encoded NUL, surrogate pairs with the lowest and highest
    // surrogate bytes, terminator inside a partial pair, lone C0 at the terminator
    stim_q = {BYTE_NUL,
              BYTE_C0, BYTE_80, BYTE_NUL,
              BYTE_ED, HI_SURR_LO, 8'h01, BYTE_ED, LO_SURR_LO, 8'h01, BYTE_NUL,
              BYTE_ED, HI_SURR_HI, 8'hFF, BYTE_ED, LO_SURR_HI, 8'hFF, BYTE_NUL,
              BYTE_ED, 8'hA5, BYTE_ED, BYTE_NUL,
              BYTE_C0, BYTE_NUL};

    while (stim_q.size() < 404) begin
      sel = $urandom_range(0, 99);
      p   = '{BYTE_ED, 8'($urandom_range(HI_SURR_LO, HI_SURR_HI)), 8'($urandom_range(1, 255)),
              BYTE_ED, 8'($urandom_range(LO_SURR_LO, LO_SURR_HI)), 8'($urandom_range(1, 255))};
      if (sel < 30) begin
        foreach (p[i]) stim_q.push_back(p[i]);
      end else if (sel < 45) begin
        stim_q.push_back(BYTE_C0);
        stim_q.push_back(BYTE_80);
      end else if (sel < 65) begin
        stim_q.push_back(8'($urandom_range(1, 255)));
      end else if (sel < 75) begin
        // a pair prefix, then any byte, which may break it
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++) stim_q.push_back(p[i]);
        stim_q.push_back(8'($urandom_range(0, 255)));
      end else if (sel < 80) begin
        stim_q.push_back(BYTE_C0);
        stim_q.push_back(8'($urandom_range(0, 255)));
      end else if (sel < 90) begin
        stim_q.push_back(BYTE_NUL);
      end else begin
        len = $urandom_range(1, 6);
        repeat (len) stim_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
      end
    end
    stim_q.push_back(BYTE_NUL);

    for (int i = 0; i < stim_q.size(); i++) begin
      quiet_in = (i >= 120 && i < 180);
      if (i == 260) begin
        // drain everything before going on
        @(negedge clk) push <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
      end
      send_item(stim_q[i]);
    end
    @(negedge clk) push <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d items never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    int gap;
    int n_out;
    pop   = 1'b0;
    n_out = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = (n_out % 150 >= 60 && n_out % 150 < 100) ? 0 : $urandom_range(0, 8);
      @(negedge clk);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      sb.check_result(out_byte, out_end_of_string);
      n_out++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end
endmodule

// ----- sim.f -----
hdl/mutf8_pkg.sv
hdl/mutf8_front.sv
hdl/mutf8_queue.sv
hdl/mutf8_back.sv
hdl/modified_utf8_to_utf8.sv
tb/tb_modified_utf8_to_utf8.sv
